// ===== design/lzwd_pkg.sv =====
`default_nettype none

package lzwd_pkg;

    // defaults for the top level parameters
    localparam int DEF_DICT_SIZE     = 4096;
    localparam int DEF_MAX_CODE_BITS = 12;
    localparam int DEF_LENGTH_BITS   = 20;

    // special codes
    localparam int CODE_CLEAR = 256;
    localparam int CODE_SKIP  = 257;
    localparam int CODE_FIRST = 258;

    // code width range and register width
    localparam int WIDTH_W   = 4;
    localparam int MIN_WIDTH = 9;

    // bit buffer
    localparam int BUF_W      = 32;
    localparam int HELD_W     = 6;
    localparam int PUSH_LIMIT = 24;

    // string stack
    localparam int STACK_DEPTH = 4096;
    localparam int STACK_AW    = 12;
    localparam int DEPTH_W     = STACK_AW + 1;

    // item action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    // sequencer to bit buffer
    typedef struct packed {
        logic       push;
        logic       take;
        logic [7:0] data;
        logic       last;
    } bb_ctrl_t;

    // bit buffer to sequencer
    typedef struct packed {
        logic ended;
        logic empty;
        logic code_ready;
        logic room;
    } bb_status_t;

endpackage

`default_nettype wire

// ===== design/lzwd_if.sv =====
`default_nettype none

// input items
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, action, in_byte, in_last, input ready);
    modport sink (input valid, action, in_byte, in_last, output ready);
endinterface

// result items
interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       push_accepted;
    logic       finished;
    logic       error;

    modport source (output valid, out_byte, out_valid, push_accepted, finished, error,
                    input ready);
    modport sink (input valid, out_byte, out_valid, push_accepted, finished, error,
                  output ready);
endinterface

// output length register writes
interface lzwd_cfg_if #(parameter int W = 20);
    logic         valid;
    logic         ready;
    logic [W-1:0] output_length;

    modport source (output valid, output_length, input ready);
    modport sink (input valid, output_length, output ready);
endinterface

`default_nettype wire

// ===== design/lzwd_ram.sv =====
`default_nettype none

module lzwd_ram
    import lzwd_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [W-1:0]             wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // one registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lzwd_bitbuf.sv =====
`default_nettype none

module lzwd_bitbuf
    import lzwd_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire bb_ctrl_t                 ctrl,
    input  wire logic [WIDTH_W-1:0]       code_width,
    output bb_status_t                    status,
    output logic      [MAX_CODE_BITS-1:0] code
);

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic              ended_reg, ended_next;

    logic              full_code;
    logic [BUF_W-1:0]  mask;
    logic [BUF_W-1:0]  shifted;
    logic [HELD_W-1:0] held_after;
    logic [HELD_W-1:0] width_ext;

    // code extraction, msb first, zero padded at the tail
    always_comb
    begin
        width_ext = HELD_W'(code_width);
        full_code = (held_reg >= width_ext);
        mask      = (BUF_W'(1) << code_width) - BUF_W'(1);
        if (full_code)
        begin
            shifted    = buf_reg >> (held_reg - width_ext);
            held_after = held_reg - width_ext;
        end
        else
        begin
            shifted    = buf_reg << (width_ext - held_reg);
            held_after = '0;
        end
        code = MAX_CODE_BITS'(shifted & mask);
    end

    assign status.ended      = ended_reg;
    assign status.empty      = (held_reg == '0);
    assign status.code_ready = full_code || (ended_reg && (held_reg != '0));
    assign status.room       = (held_reg <= HELD_W'(PUSH_LIMIT));

    // push and take
    always_comb
    begin
        buf_next   = buf_reg;
        held_next  = held_reg;
        ended_next = ended_reg;
        if (ctrl.push)
        begin
            buf_next   = {buf_reg[BUF_W-9:0], ctrl.data};
            held_next  = held_reg + HELD_W'(8);
            ended_next = ended_reg | ctrl.last;
        end
        else if (ctrl.take)
        begin
            buf_next  = buf_reg & ((BUF_W'(1) << held_after) - BUF_W'(1));
            held_next = held_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            held_reg  <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            buf_reg   <= buf_next;
            held_reg  <= held_next;
            ended_reg <= ended_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lzw_variable_width_decoder.sv =====
`default_nettype none

// channel  | dir | handshake      | payload
// items    | in  | valid / ready  | action, in_byte, in_last
// results  | out | valid / ready  | out_byte, out_valid, push_accepted, finished, error
// cfg      | in  | valid / ready  | output_length (always ready)
//
// a push goes through S_PUSH to S_RESULT; a pull that pops a waiting byte goes through
// S_POP_RD and S_POP_USE; a pull that decodes does one table read per string byte, then
// S_ADD and S_WIDEN per code, all through one prefix/suffix read port
// one item at a time; the next item is taken while the result beat waits
// reset is asynchronous, no clearing pass: tables and stack are read only where written

module lzw_variable_width_decoder
    import lzwd_pkg::*;
#(
    parameter int DICT_SIZE     = DEF_DICT_SIZE,
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
    parameter int LENGTH_BITS   = DEF_LENGTH_BITS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    lzwd_in_if.sink   items,
    lzwd_out_if.source results,
    lzwd_cfg_if.sink  cfg
);

    localparam int TAW = $clog2(DICT_SIZE);
    localparam int SW  = ((TAW > MAX_CODE_BITS) ? TAW : MAX_CODE_BITS) + 1;
    localparam int MCB = MAX_CODE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH, S_PULL, S_DECODE, S_WALK_RD, S_WALK_USE,
        S_KW_FIX, S_ADD, S_WIDEN, S_POP_RD, S_POP_USE, S_RESULT
    } state_t;

    state_t                 state_reg;
    logic [7:0]             byte_reg;
    logic                   last_reg;
    logic [DEPTH_W-1:0]     depth_reg;
    logic [WIDTH_W-1:0]     width_reg;
    logic [TAW-1:0]         count_reg;
    logic [MCB-1:0]         prev_reg;
    logic                   may_add_reg;
    logic [LENGTH_BITS-1:0] emitted_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic                   err_reg;
    logic [MCB-1:0]         code_reg;
    logic [MCB-1:0]         cur_reg;
    logic                   kw_reg;
    logic [7:0]             head_reg;
    logic                   res_valid_reg;
    logic [7:0]             res_byte_reg;
    logic                   res_out_valid_reg;
    logic                   res_accepted_reg;
    logic                   res_finished_reg;
    logic                   res_error_reg;
    logic                   pend_valid_reg;
    logic [7:0]             pend_byte_reg;
    logic                   pend_accepted_reg;

    bb_ctrl_t               bb_ctrl;
    bb_status_t             bb_status;
    logic [MCB-1:0]         bb_code;

    logic                   tab_we, tab_re;
    logic [TAW-1:0]         tab_waddr, tab_raddr;
    logic [MCB-1:0]         prefix_q;
    logic [7:0]             suffix_q;
    logic                   stk_we, stk_re;
    logic [STACK_AW-1:0]    stk_waddr, stk_raddr;
    logic [7:0]             stk_wdata, stk_q;

    logic [SW-1:0]          next_code;
    logic                   finished_now;
    logic                   cur_is_string;
    logic                   stack_full;

    assign next_code     = SW'(CODE_FIRST) + SW'(count_reg);
    assign finished_now  = err_reg || (emitted_reg >= len_reg)
                           || (bb_status.ended && bb_status.empty && depth_reg == '0);
    assign cur_is_string = (SW'(cur_reg) >= SW'(CODE_FIRST));
    assign stack_full    = depth_reg[DEPTH_W-1];

    assign items.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    assign results.valid         = res_valid_reg;
    assign results.out_byte      = res_byte_reg;
    assign results.out_valid     = res_out_valid_reg;
    assign results.push_accepted = res_accepted_reg;
    assign results.finished      = res_finished_reg;
    assign results.error         = res_error_reg;

    // bit buffer control
    always_comb
    begin
        bb_ctrl.push = (state_reg == S_PUSH) && !finished_now && !bb_status.ended
                       && bb_status.room;
        bb_ctrl.take = (state_reg == S_PULL) && !err_reg && (emitted_reg < len_reg)
                       && (depth_reg == '0) && bb_status.code_ready;
        bb_ctrl.data = byte_reg;
        bb_ctrl.last = last_reg;
    end

    // memory ports
    always_comb
    begin
        tab_we    = (state_reg == S_ADD) && may_add_reg && (next_code < SW'(DICT_SIZE));
        tab_waddr = TAW'(next_code);
        tab_re    = (state_reg == S_WALK_RD) && cur_is_string && !stack_full;
        tab_raddr = TAW'(cur_reg);
        stk_re    = (state_reg == S_POP_RD);
        stk_raddr = STACK_AW'(depth_reg - DEPTH_W'(1));
        stk_we    = 1'b0;
        stk_waddr = STACK_AW'(depth_reg);
        stk_wdata = suffix_q;
        unique case (state_reg)
            S_DECODE:
            begin
                stk_we    = (SW'(code_reg) < SW'(CODE_CLEAR));
                stk_waddr = '0;
                stk_wdata = code_reg[7:0];
            end
            S_WALK_RD:
            begin
                stk_we    = !cur_is_string && !stack_full;
                stk_wdata = cur_reg[7:0];
            end
            S_WALK_USE:
            begin
                stk_we = 1'b1;
            end
            S_KW_FIX:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = head_reg;
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    lzwd_bitbuf #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_bitbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (bb_ctrl),
        .code_width(width_reg),
        .status    (bb_status),
        .code      (bb_code)
    );

    lzwd_ram #(.W(MCB), .DEPTH(DICT_SIZE)) u_prefix (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(prev_reg),
        .re(tab_re), .raddr(tab_raddr), .rdata(prefix_q)
    );

    lzwd_ram #(.W(8), .DEPTH(DICT_SIZE)) u_suffix (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(head_reg),
        .re(tab_re), .raddr(tab_raddr), .rdata(suffix_q)
    );

    lzwd_ram #(.W(8), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_q)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            byte_reg          <= '0;
            last_reg          <= 1'b0;
            depth_reg         <= '0;
            width_reg         <= WIDTH_W'(MIN_WIDTH);
            count_reg         <= '0;
            prev_reg          <= '0;
            may_add_reg       <= 1'b0;
            emitted_reg       <= '0;
            len_reg           <= LENGTH_BITS'(1);
            err_reg           <= 1'b0;
            code_reg          <= '0;
            cur_reg           <= '0;
            kw_reg            <= 1'b0;
            head_reg          <= '0;
            res_valid_reg     <= 1'b0;
            res_byte_reg      <= '0;
            res_out_valid_reg <= 1'b0;
            res_accepted_reg  <= 1'b0;
            res_finished_reg  <= 1'b0;
            res_error_reg     <= 1'b0;
            pend_valid_reg    <= 1'b0;
            pend_byte_reg     <= '0;
            pend_accepted_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                len_reg <= LENGTH_BITS'(cfg.output_length);
            end
            // the result state reloads the beat itself when it frees the register
            if (results.valid && results.ready && state_reg != S_RESULT)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (items.valid)
                    begin
                        byte_reg          <= items.in_byte;
                        last_reg          <= items.in_last;
                        pend_valid_reg    <= 1'b0;
                        pend_byte_reg     <= '0;
                        pend_accepted_reg <= 1'b0;
                        state_reg         <= (items.action == ACT_PULL) ? S_PULL : S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    pend_accepted_reg <= bb_ctrl.push;
                    state_reg         <= S_RESULT;
                end
                S_PULL:
                begin
                    priority if (err_reg || emitted_reg >= len_reg)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else if (depth_reg != '0)
                    begin
                        state_reg <= S_POP_RD;
                    end
                    else if (bb_status.code_ready)
                    begin
                        code_reg  <= bb_code;
                        state_reg <= S_DECODE;
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_DECODE:
                begin
                    priority if (SW'(code_reg) == SW'(CODE_CLEAR))
                    begin
                        width_reg   <= WIDTH_W'(MIN_WIDTH);
                        count_reg   <= '0;
                        may_add_reg <= 1'b0;
                        state_reg   <= S_WIDEN;
                    end
                    else if (SW'(code_reg) == SW'(CODE_SKIP))
                    begin
                        state_reg <= S_WIDEN;
                    end
                    else if (SW'(code_reg) < SW'(CODE_CLEAR))
                    begin
                        depth_reg <= DEPTH_W'(1);
                        head_reg  <= code_reg[7:0];
                        state_reg <= S_ADD;
                    end
                    else if (SW'(code_reg) < next_code)
                    begin
                        depth_reg <= '0;
                        cur_reg   <= code_reg;
                        kw_reg    <= 1'b0;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        // code not yet defined: previous string plus its first byte
                        depth_reg <= DEPTH_W'(1);
                        cur_reg   <= prev_reg;
                        kw_reg    <= 1'b1;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_WALK_RD:
                begin
                    if (stack_full)
                    begin
                        err_reg   <= 1'b1;
                        depth_reg <= '0;
                        state_reg <= S_RESULT;
                    end
                    else if (cur_is_string)
                    begin
                        state_reg <= S_WALK_USE;
                    end
                    else
                    begin
                        head_reg  <= cur_reg[7:0];
                        depth_reg <= depth_reg + DEPTH_W'(1);
                        state_reg <= kw_reg ? S_KW_FIX : S_ADD;
                    end
                end
                S_WALK_USE:
                begin
                    depth_reg <= depth_reg + DEPTH_W'(1);
                    cur_reg   <= prefix_q;
                    state_reg <= S_WALK_RD;
                end
                S_KW_FIX:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (tab_we)
                    begin
                        count_reg <= count_reg + TAW'(1);
                    end
                    prev_reg    <= code_reg;
                    may_add_reg <= 1'b1;
                    state_reg   <= S_WIDEN;
                end
                S_WIDEN:
                begin
                    if (next_code == (SW'(1) << width_reg)
                        && width_reg < WIDTH_W'(MAX_CODE_BITS))
                    begin
                        width_reg <= width_reg + WIDTH_W'(1);
                    end
                    state_reg <= S_PULL;
                end
                S_POP_RD:
                begin
                    depth_reg <= depth_reg - DEPTH_W'(1);
                    state_reg <= S_POP_USE;
                end
                S_POP_USE:
                begin
                    pend_valid_reg <= 1'b1;
                    pend_byte_reg  <= stk_q;
                    emitted_reg    <= emitted_reg + LENGTH_BITS'(1);
                    state_reg      <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!res_valid_reg || results.ready)
                    begin
                        res_valid_reg     <= 1'b1;
                        res_byte_reg      <= pend_byte_reg;
                        res_out_valid_reg <= pend_valid_reg;
                        res_accepted_reg  <= pend_accepted_reg;
                        res_finished_reg  <= finished_now;
                        res_error_reg     <= err_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/lzwd_checker.sv =====
`default_nettype none

module lzwd_checker
    import lzwd_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic res_out_valid,
    input wire logic res_accepted,
    input wire logic res_finished,
    input wire logic res_error
);

    // a stalled result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // a beat is either a pull or a push answer
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_out_valid && res_accepted))
        else $error("byte and push accept in one beat");

    // error forces finished
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_error |-> res_finished)
        else $error("error without finished");

    // nothing leaves or enters once in error
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_error |-> !res_out_valid && !res_accepted)
        else $error("activity after error");

endmodule

bind lzw_variable_width_decoder lzwd_checker u_lzwd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_out_valid(results.out_valid),
    .res_accepted (results.push_accepted),
    .res_finished (results.finished),
    .res_error    (results.error)
);

`default_nettype wire
